// ===== hdl/lrgd_pkg.sv =====
// Shared types and constants for the linear regression gradient descent trainer.
// No dependencies; used by every module of the block except lrgd_ram.
`default_nettype none

package lrgd_pkg;

  localparam int ROWS_DEF = 1024;
  localparam int FEAT_DEF = 32;

  localparam int IDX_W  = 6;   // weight index, 32 = bias
  localparam int DATA_W = 32;  // Q16.16 values
  localparam int PROD_W = 64;  // 32x32 product
  localparam int ACC_W  = 56;  // prediction sum, bias plus 32 shifted terms
  localparam int SUM_W  = 66;  // gradient sum over up to 65536 rows
  localparam int ESUM_W = 64;  // squared error sum
  localparam int DEN_W  = 17;  // active row count 1..65536
  localparam int MSE_W  = 48;
  localparam int LR_W   = 16;
  localparam int RC_W   = 11;
  localparam int EP_W   = 16;
  localparam int CFG_W  = 16;
  localparam int CFGI_W = 2;

  localparam logic [IDX_W-1:0] BIAS_IDX = 6'd32;

  localparam logic [RC_W-1:0] ROW_COUNT_RST  = 11'd1;
  localparam logic [EP_W-1:0] EPOCH_COUNT_RST = 16'd1;
  localparam logic [LR_W-1:0] LEARN_RATE_RST  = 16'd655;

  localparam logic [CFGI_W-1:0] CFG_ROW_COUNT   = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_EPOCH_COUNT = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_LEARN_RATE  = 2'd2;

  localparam logic [2:0] KIND_LOAD_FEAT = 3'd0;
  localparam logic [2:0] KIND_LOAD_TGT  = 3'd1;
  localparam logic [2:0] KIND_TRAIN     = 3'd2;
  localparam logic [2:0] KIND_EVAL      = 3'd3;
  localparam logic [2:0] KIND_SET_W     = 3'd4;

  typedef enum logic [1:0] {
    MUL_XW = 2'd0,  // feature times weight
    MUL_XE = 2'd1,  // feature times error
    MUL_EE = 2'd2   // error squared
  } mul_sel_t;

  typedef struct packed {
    logic     ld_feat;
    logic     ld_tgt;
    logic     ld_w;
    mul_sel_t mul_sel;
    logic     acc_en;
    logic     acc_first;
    logic     err_wr;
    logic     sq_acc;
    logic     sq_first;
    logic     g_acc;
    logic     g_first;
    logic     g_bias;
    logic     div_start;
    logic     div_mse;
    logic     step_mul;
    logic     upd;
    logic     emit_w;
    logic     emit_last;
    logic     emit_mse;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/lrgd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lrgd_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                            wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                            rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/lrgd_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on lrgd_pkg for operand widths.
`default_nettype none

module lrgd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lrgd_pkg::SUM_W-1:0]    num,
  input  logic [lrgd_pkg::DEN_W-1:0]    den,
  output logic                          done,
  output logic [lrgd_pkg::SUM_W-1:0]    quot
);

  localparam int NW = lrgd_pkg::SUM_W;
  localparam int DW = lrgd_pkg::DEN_W;
  localparam int CW = $clog2(NW);

  logic          running;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_dif;
  logic          fits;

  always_comb begin
    rem_sh  = {rem, quot[NW-1]};
    fits    = rem_sh >= {1'b0, den};
    rem_dif = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        quot    <= num;
      end else if (running) begin
        rem  <= fits ? rem_dif[DW-1:0] : rem_sh[DW-1:0];
        quot <= {quot[NW-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lrgd_ctrl.sv =====
// Controller: command decode, epoch/row/feature sequencing, datapath commands.
// Depends on lrgd_pkg.
`default_nettype none

module lrgd_ctrl #(
  parameter int ROWS     = lrgd_pkg::ROWS_DEF,
  parameter int FEATURES = lrgd_pkg::FEAT_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              start,
  input  logic [2:0]                                        kind,
  input  logic [lrgd_pkg::RC_W-1:0]                         row_count,
  input  logic [lrgd_pkg::EP_W-1:0]                         epoch_count,
  input  lrgd_pkg::dp_stat_t                                stat,
  output logic                                              busy,
  output lrgd_pkg::dp_cmd_t                                 cmd,
  output logic [(ROWS*FEATURES > 1 ? $clog2(ROWS*FEATURES) : 1)-1:0] feat_addr,
  output logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0]          row_idx,
  output logic [lrgd_pkg::IDX_W-1:0]                        feat_idx,
  output logic [lrgd_pkg::DEN_W-1:0]                        div_den
);

  localparam int AW = (ROWS*FEATURES > 1) ? $clog2(ROWS*FEATURES) : 1;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int XW = lrgd_pkg::IDX_W;
  localparam int DW = lrgd_pkg::DEN_W;
  localparam int EW = lrgd_pkg::EP_W;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_E_RD  = 18'h00002,
    S_E_MUL = 18'h00004,
    S_E_ACC = 18'h00008,
    S_E_ERR = 18'h00010,
    S_E_SQ  = 18'h00020,
    S_E_SQA = 18'h00040,
    S_G_RD  = 18'h00080,
    S_G_MUL = 18'h00100,
    S_G_ACC = 18'h00200,
    S_G_DST = 18'h00400,
    S_G_DWT = 18'h00800,
    S_G_STP = 18'h01000,
    S_G_UPD = 18'h02000,
    S_M_DST = 18'h04000,
    S_M_DWT = 18'h08000,
    S_M_OUT = 18'h10000,
    S_EMIT  = 18'h20000
  } state_t;

  state_t        state, state_next;
  logic          eval_mode, eval_mode_next;
  logic [EW-1:0] epoch, epoch_next;
  logic [RW-1:0] row_idx_next;
  logic [XW-1:0] feat_idx_next;
  logic [AW-1:0] feat_addr_next;

  logic [DW-1:0] rc_ext;
  logic [DW-1:0] n_m1_full;
  logic [RW-1:0] n_m1;
  logic          last_row;
  logic          last_feat;
  logic          is_bias;

  // active row count clamped to 1..ROWS
  always_comb begin
    rc_ext = DW'(row_count);
    if (rc_ext == '0) begin
      div_den = DW'(1);
    end else if (rc_ext > DW'(ROWS)) begin
      div_den = DW'(ROWS);
    end else begin
      div_den = rc_ext;
    end
    n_m1_full = div_den - DW'(1);
    n_m1      = n_m1_full[RW-1:0];
    last_row  = row_idx == n_m1;
    last_feat = feat_idx == XW'(FEATURES - 1);
    is_bias   = feat_idx == lrgd_pkg::BIAS_IDX;
  end

  assign busy = state != S_IDLE;

  always_comb begin
    state_next     = state;
    eval_mode_next = eval_mode;
    epoch_next     = epoch;
    row_idx_next   = row_idx;
    feat_idx_next  = feat_idx;
    feat_addr_next = feat_addr;
    cmd            = '0;
    cmd.mul_sel    = lrgd_pkg::MUL_XW;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.ld_feat = kind == lrgd_pkg::KIND_LOAD_FEAT;
          cmd.ld_tgt  = kind == lrgd_pkg::KIND_LOAD_TGT;
          cmd.ld_w    = kind == lrgd_pkg::KIND_SET_W;
          row_idx_next   = '0;
          feat_idx_next  = '0;
          feat_addr_next = '0;
          epoch_next     = '0;
          if (kind == lrgd_pkg::KIND_TRAIN) begin
            eval_mode_next = 1'b0;
            state_next     = (epoch_count == '0) ? S_EMIT : S_E_RD;
          end else if (kind == lrgd_pkg::KIND_EVAL) begin
            eval_mode_next = 1'b1;
            state_next     = S_E_RD;
          end
        end
      end
      S_E_RD: begin
        state_next = S_E_MUL;
      end
      S_E_MUL: begin
        cmd.mul_sel = lrgd_pkg::MUL_XW;
        state_next  = S_E_ACC;
      end
      S_E_ACC: begin
        cmd.acc_en     = 1'b1;
        cmd.acc_first  = feat_idx == '0;
        feat_addr_next = feat_addr + AW'(1);
        if (last_feat) begin
          feat_idx_next = '0;
          state_next    = S_E_ERR;
        end else begin
          feat_idx_next = feat_idx + XW'(1);
          state_next    = S_E_RD;
        end
      end
      S_E_ERR, S_E_SQA: begin
        if (state == S_E_ERR) begin
          cmd.err_wr = 1'b1;
        end else begin
          cmd.sq_acc   = 1'b1;
          cmd.sq_first = row_idx == '0;
        end
        if (state == S_E_ERR && eval_mode) begin
          state_next = S_E_SQ;
        end else if (last_row) begin
          row_idx_next = '0;
          if (eval_mode) begin
            state_next = S_M_DST;
          end else begin
            feat_idx_next  = '0;
            feat_addr_next = '0;
            state_next     = S_G_RD;
          end
        end else begin
          row_idx_next = row_idx + RW'(1);
          state_next   = S_E_RD;
        end
      end
      S_E_SQ: begin
        cmd.mul_sel = lrgd_pkg::MUL_EE;
        state_next  = S_E_SQA;
      end
      S_G_RD: begin
        state_next = is_bias ? S_G_ACC : S_G_MUL;
      end
      S_G_MUL: begin
        cmd.mul_sel = lrgd_pkg::MUL_XE;
        state_next  = S_G_ACC;
      end
      S_G_ACC: begin
        cmd.g_acc      = 1'b1;
        cmd.g_first    = row_idx == '0;
        cmd.g_bias     = is_bias;
        feat_addr_next = feat_addr + AW'(FEATURES);
        if (last_row) begin
          state_next = S_G_DST;
        end else begin
          row_idx_next = row_idx + RW'(1);
          state_next   = S_G_RD;
        end
      end
      S_G_DST: begin
        cmd.div_start = 1'b1;
        state_next    = S_G_DWT;
      end
      S_G_DWT: begin
        if (stat.div_done) begin
          state_next = S_G_STP;
        end
      end
      S_G_STP: begin
        cmd.step_mul = 1'b1;
        state_next   = S_G_UPD;
      end
      S_G_UPD: begin
        cmd.upd      = 1'b1;
        row_idx_next = '0;
        if (is_bias) begin
          epoch_next     = epoch + EW'(1);
          feat_idx_next  = '0;
          feat_addr_next = '0;
          if ((epoch + EW'(1)) == epoch_count) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_E_RD;
          end
        end else if (last_feat) begin
          feat_idx_next = lrgd_pkg::BIAS_IDX;
          state_next    = S_G_RD;
        end else begin
          feat_idx_next  = feat_idx + XW'(1);
          feat_addr_next = AW'(feat_idx + XW'(1));
          state_next     = S_G_RD;
        end
      end
      S_M_DST: begin
        cmd.div_start = 1'b1;
        cmd.div_mse   = 1'b1;
        state_next    = S_M_DWT;
      end
      S_M_DWT: begin
        if (stat.div_done) begin
          state_next = S_M_OUT;
        end
      end
      S_M_OUT: begin
        cmd.emit_mse = 1'b1;
        state_next   = S_IDLE;
      end
      S_EMIT: begin
        cmd.emit_w    = 1'b1;
        cmd.emit_last = is_bias;
        if (is_bias) begin
          state_next = S_IDLE;
        end else if (last_feat) begin
          feat_idx_next = lrgd_pkg::BIAS_IDX;
        end else begin
          feat_idx_next = feat_idx + XW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      eval_mode <= 1'b0;
      epoch     <= '0;
      row_idx   <= '0;
      feat_idx  <= '0;
      feat_addr <= '0;
    end else begin
      state     <= state_next;
      eval_mode <= eval_mode_next;
      epoch     <= epoch_next;
      row_idx   <= row_idx_next;
      feat_idx  <= feat_idx_next;
      feat_addr <= feat_addr_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lrgd_dp.sv =====
// Datapath: sample stores, weights, shared multiplier, accumulators, divider, result regs.
// Depends on lrgd_pkg, lrgd_ram and lrgd_div.
`default_nettype none

module lrgd_dp #(
  parameter int ROWS     = lrgd_pkg::ROWS_DEF,
  parameter int FEATURES = lrgd_pkg::FEAT_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  lrgd_pkg::dp_cmd_t                                 cmd,
  output lrgd_pkg::dp_stat_t                                stat,
  input  logic [9:0]                                        row,
  input  logic [lrgd_pkg::IDX_W-1:0]                        column,
  input  logic signed [lrgd_pkg::DATA_W-1:0]                value,
  input  logic [lrgd_pkg::LR_W-1:0]                         learning_rate,
  input  logic [(ROWS*FEATURES > 1 ? $clog2(ROWS*FEATURES) : 1)-1:0] feat_addr,
  input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0]          row_idx,
  input  logic [lrgd_pkg::IDX_W-1:0]                        feat_idx,
  input  logic [lrgd_pkg::DEN_W-1:0]                        div_den,
  output logic                                              strobe,
  output logic [lrgd_pkg::IDX_W-1:0]                        weight_index,
  output logic signed [lrgd_pkg::DATA_W-1:0]                weight_value,
  output logic [lrgd_pkg::MSE_W-1:0]                        mean_sq_error,
  output logic                                              last
);

  localparam int AW = (ROWS*FEATURES > 1) ? $clog2(ROWS*FEATURES) : 1;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int XW = lrgd_pkg::IDX_W;
  localparam int DW = lrgd_pkg::DATA_W;
  localparam int PW = lrgd_pkg::PROD_W;
  localparam int CW = lrgd_pkg::ACC_W;
  localparam int SW = lrgd_pkg::SUM_W;
  localparam int QW = lrgd_pkg::ESUM_W;
  localparam int MW = lrgd_pkg::MSE_W;

  localparam logic [48:0] Q_LIM = {1'b1, 48'b0};

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -68'sh0_0000_0000_8000_0000) begin
      return -32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // ---------------- stores ----------------
  logic [31:0]          ld_lin;
  logic                 feat_we;
  logic                 tgt_we;
  logic signed [DW-1:0] feat_q;
  logic signed [DW-1:0] tgt_q;
  logic signed [DW-1:0] err_q;
  logic signed [DW-1:0] err_next;

  always_comb begin
    ld_lin  = 32'(row) * 32'(FEATURES) + 32'(column);
    feat_we = cmd.ld_feat && (32'(row) < 32'(ROWS)) && (column < XW'(FEATURES));
    tgt_we  = cmd.ld_tgt && (32'(row) < 32'(ROWS));
  end

  lrgd_ram #(.W(DW), .DEPTH(ROWS*FEATURES)) u_feat_ram (
    .clk   (clk),
    .we    (feat_we),
    .waddr (ld_lin[AW-1:0]),
    .wdata (value),
    .raddr (feat_addr),
    .rdata (feat_q)
  );

  lrgd_ram #(.W(DW), .DEPTH(ROWS)) u_tgt_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (RW'(row)),
    .wdata (value),
    .raddr (row_idx),
    .rdata (tgt_q)
  );

  lrgd_ram #(.W(DW), .DEPTH(ROWS)) u_err_ram (
    .clk   (clk),
    .we    (cmd.err_wr),
    .waddr (row_idx),
    .wdata (err_next),
    .raddr (row_idx),
    .rdata (err_q)
  );

  // ---------------- weights ----------------
  // feature weights in a small register file, bias in its own register
  logic signed [DW-1:0] weights [FEATURES];
  logic signed [DW-1:0] bias;
  logic signed [DW-1:0] w_sel;
  logic signed [DW-1:0] w_new;
  logic                 sel_bias;

  assign sel_bias = feat_idx == lrgd_pkg::BIAS_IDX;
  assign w_sel    = sel_bias ? bias : weights[feat_idx[FW-1:0]];

  // ---------------- multiplier ----------------
  logic signed [DW-1:0] mul_a;
  logic signed [DW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [47:0]   term;
  logic signed [DW-1:0] err_reg;

  always_comb begin
    unique case (cmd.mul_sel)
      lrgd_pkg::MUL_XW: begin
        mul_a = feat_q;
        mul_b = w_sel;
      end
      lrgd_pkg::MUL_XE: begin
        mul_a = feat_q;
        mul_b = err_q;
      end
      lrgd_pkg::MUL_EE: begin
        mul_a = err_reg;
        mul_b = err_reg;
      end
      default: begin
        mul_a = feat_q;
        mul_b = w_sel;
      end
    endcase
    term = prod[PW-1:16];  // floor shift by 16
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ---------------- accumulators ----------------
  logic signed [CW-1:0] acc;
  logic signed [DW-1:0] pred;
  logic signed [67:0]   diff;
  logic [QW-1:0]        esum;
  logic signed [SW-1:0] gsum;

  always_comb begin
    pred     = sat32(68'(acc));
    diff     = 68'(pred) - 68'(tgt_q);
    err_next = sat32(diff);
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      acc <= (cmd.acc_first ? CW'(bias) : acc) + CW'(term);
    end
    if (cmd.err_wr) begin
      err_reg <= err_next;
    end
    if (cmd.sq_acc) begin
      esum <= (cmd.sq_first ? '0 : esum) + QW'(prod[PW-1:16]);
    end
    if (cmd.g_acc) begin
      gsum <= (cmd.g_first ? '0 : gsum) + (cmd.g_bias ? SW'(err_q) : SW'(term));
    end
  end

  // ---------------- divide and step ----------------
  logic [SW-1:0]        div_num;
  logic [SW-1:0]        quot;
  logic                 div_done;
  logic                 neg_q;
  logic [48:0]          qmag;
  logic signed [50:0]   g2;
  logic signed [50:0]   gval;
  logic signed [16:0]   lr_s;
  logic signed [67:0]   step_prod;
  logic signed [51:0]   step;
  logic [MW-1:0]        mse;

  always_comb begin
    if (cmd.div_mse) begin
      div_num = SW'(esum);
    end else begin
      div_num = gsum[SW-1] ? SW'(-gsum) : SW'(gsum);
    end
    // beyond 2^48 the step saturates the weight for any nonzero rate
    qmag = (quot > SW'(Q_LIM)) ? Q_LIM : quot[48:0];
    g2   = {1'b0, qmag, 1'b0};
    gval = neg_q ? -g2 : g2;
    lr_s = {1'b0, learning_rate};
    step = step_prod[67:16];
    w_new = sat32(68'(w_sel) - 68'(step));
    mse  = (quot > SW'({MW{1'b1}})) ? {MW{1'b1}} : quot[MW-1:0];
  end

  lrgd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  assign stat.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_q <= !cmd.div_mse && gsum[SW-1];
    end
    if (cmd.step_mul) begin
      step_prod <= gval * lr_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FEATURES; i++) begin
        weights[i] <= '0;
      end
      bias <= '0;
    end else if (cmd.upd) begin
      if (sel_bias) begin
        bias <= w_new;
      end else begin
        weights[feat_idx[FW-1:0]] <= w_new;
      end
    end else if (cmd.ld_w) begin
      if (column == lrgd_pkg::BIAS_IDX) begin
        bias <= value;
      end else if (column < XW'(FEATURES)) begin
        weights[column[FW-1:0]] <= value;
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_w || cmd.emit_mse;
    end
    weight_index  <= cmd.emit_w ? feat_idx : '0;
    weight_value  <= cmd.emit_w ? w_sel : '0;
    mean_sq_error <= cmd.emit_mse ? mse : '0;
    last          <= cmd.emit_mse || cmd.emit_last;
  end

endmodule

`default_nettype wire

// ===== hdl/linear_regression_gd_trainer.sv =====
// Top level of the linear regression trainer: configuration registers and the
// controller/datapath pair. Depends on lrgd_pkg, lrgd_ctrl and lrgd_dp.
//
// Channel   Ports                                         Transfer
// command   start, busy, kind, row, column, value        start & !busy
// result    strobe, weight_index, weight_value,          strobe (one cycle,
//           mean_sq_error, last                          no back-pressure)
// config    cfg_we, cfg_index, cfg_data                  cfg_we
//
// Loads (feature, target, set weight) never raise busy. The row/feature loop
// steps each element through read, multiply and accumulate states on the
// single shared multiplier (the bias gradient skips the multiply), and each
// divide holds the loop while the bit-serial divider runs, until its done
// flag is seen. Sync reset clears weights to zero and sets the config
// registers to their defaults; the stores hold garbage until written.
// Results leave one per cycle; the receiver cannot stall them.
`default_nettype none

module linear_regression_gd_trainer #(
  parameter int ROWS     = lrgd_pkg::ROWS_DEF,
  parameter int FEATURES = lrgd_pkg::FEAT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // command
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         kind,
  input  logic [9:0]                         row,
  input  logic [lrgd_pkg::IDX_W-1:0]         column,
  input  logic signed [lrgd_pkg::DATA_W-1:0] value,
  // configuration
  input  logic                               cfg_we,
  input  logic [lrgd_pkg::CFGI_W-1:0]        cfg_index,
  input  logic [lrgd_pkg::CFG_W-1:0]         cfg_data,
  // results
  output logic                               strobe,
  output logic [lrgd_pkg::IDX_W-1:0]         weight_index,
  output logic signed [lrgd_pkg::DATA_W-1:0] weight_value,
  output logic [lrgd_pkg::MSE_W-1:0]         mean_sq_error,
  output logic                               last
);

  localparam int AW = (ROWS*FEATURES > 1) ? $clog2(ROWS*FEATURES) : 1;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  // configuration registers; the user must write them only while idle, the block itself does not enforce it
  logic [lrgd_pkg::RC_W-1:0] row_count;
  logic [lrgd_pkg::EP_W-1:0] epoch_count;
  logic [lrgd_pkg::LR_W-1:0] learning_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= lrgd_pkg::ROW_COUNT_RST;
      epoch_count   <= lrgd_pkg::EPOCH_COUNT_RST;
      learning_rate <= lrgd_pkg::LEARN_RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrgd_pkg::CFG_ROW_COUNT:   row_count     <= cfg_data[lrgd_pkg::RC_W-1:0];
        lrgd_pkg::CFG_EPOCH_COUNT: epoch_count   <= cfg_data;
        lrgd_pkg::CFG_LEARN_RATE:  learning_rate <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lrgd_pkg::dp_cmd_t          cmd;
  lrgd_pkg::dp_stat_t         stat;
  logic [AW-1:0]              feat_addr;
  logic [RW-1:0]              row_idx;
  logic [lrgd_pkg::IDX_W-1:0] feat_idx;
  logic [lrgd_pkg::DEN_W-1:0] div_den;

  lrgd_ctrl #(.ROWS(ROWS), .FEATURES(FEATURES)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .kind        (kind),
    .row_count   (row_count),
    .epoch_count (epoch_count),
    .stat        (stat),
    .busy        (busy),
    .cmd         (cmd),
    .feat_addr   (feat_addr),
    .row_idx     (row_idx),
    .feat_idx    (feat_idx),
    .div_den     (div_den)
  );

  lrgd_dp #(.ROWS(ROWS), .FEATURES(FEATURES)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .row           (row),
    .column        (column),
    .value         (value),
    .learning_rate (learning_rate),
    .feat_addr     (feat_addr),
    .row_idx       (row_idx),
    .feat_idx      (feat_idx),
    .div_den       (div_den),
    .strobe        (strobe),
    .weight_index  (weight_index),
    .weight_value  (weight_value),
    .mean_sq_error (mean_sq_error),
    .last          (last)
  );

endmodule

`default_nettype wire

// ===== tb/linear_regression_gd_trainer_tb.sv =====
// Self-checking testbench for linear_regression_gd_trainer: a scoreboard class
// predicts trained weights and MSE from every accepted command; tasks drive it.
// Depends on lrgd_pkg and the linear_regression_gd_trainer RTL.
`timescale 1ns / 1ps

typedef struct {
  logic [lrgd_pkg::IDX_W-1:0]  idx;
  logic [lrgd_pkg::DATA_W-1:0] wval;
  logic [lrgd_pkg::MSE_W-1:0]  mse;
  logic                        last;
} lr_result_t;

class lr_scoreboard;
  localparam int NROWS = 1024;
  localparam int NFEAT = 32;

  int feat_mem [NROWS*NFEAT];
  int tgt_mem  [NROWS];
  int err_mem  [NROWS];
  int wts      [33];
  int unsigned row_cnt, epoch_cnt, lrate;
  lr_result_t  pending_q [$];
  int          fail_cnt;

  function new();
    foreach (wts[i]) wts[i] = 0;
    row_cnt   = 32'(lrgd_pkg::ROW_COUNT_RST);
    epoch_cnt = 32'(lrgd_pkg::EPOCH_COUNT_RST);
    lrate     = 32'(lrgd_pkg::LEARN_RATE_RST);
    fail_cnt  = 0;
  endfunction

  function int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function void set_cfg(logic [lrgd_pkg::CFGI_W-1:0] idx, logic [lrgd_pkg::CFG_W-1:0] data);
    case (idx)
      lrgd_pkg::CFG_ROW_COUNT:   row_cnt   = 32'(data[lrgd_pkg::RC_W-1:0]);
      lrgd_pkg::CFG_EPOCH_COUNT: epoch_cnt = 32'(data);
      lrgd_pkg::CFG_LEARN_RATE:  lrate     = 32'(data);
      default: ;
    endcase
  endfunction

  function int unsigned active_rows();
    if (row_cnt < 1) return 1;
    if (row_cnt > NROWS) return NROWS;
    return row_cnt;
  endfunction

  // prediction minus target per row; prediction and difference both saturated
  function void refresh_errors(int unsigned n);
    longint acc;
    for (int r = 0; r < n; r++) begin
      acc = longint'(wts[lrgd_pkg::BIAS_IDX]);
      for (int f = 0; f < NFEAT; f++)
        acc += (longint'(feat_mem[r*NFEAT+f]) * longint'(wts[f])) >>> 16;
      err_mem[r] = sat32(longint'(sat32(acc)) - longint'(tgt_mem[r]));
    end
  endfunction

  function int descend(int w, longint sum, int unsigned n);
    longint grad;
    grad = (sum / longint'(n)) * 2;
    return sat32(longint'(w) - ((grad * longint'(lrate)) >>> 16));
  endfunction

  function void one_epoch(int unsigned n);
    int     nxt [33];
    longint sum;
    refresh_errors(n);
    nxt = wts;
    for (int f = 0; f < NFEAT; f++) begin
      sum = 0;
      for (int r = 0; r < n; r++)
        sum += (longint'(feat_mem[r*NFEAT+f]) * longint'(err_mem[r])) >>> 16;
      nxt[f] = descend(wts[f], sum, n);
    end
    sum = 0;
    for (int r = 0; r < n; r++) sum += longint'(err_mem[r]);
    nxt[lrgd_pkg::BIAS_IDX] = descend(wts[lrgd_pkg::BIAS_IDX], sum, n);
    wts = nxt;
  endfunction

  // accepted command transfer: update state, queue the results it causes
  function void note_command(logic [2:0] k, logic [9:0] r, logic [5:0] c, int v);
    int unsigned n;
    lr_result_t  res;
    longint      esum;
    n = active_rows();
    case (k)
      lrgd_pkg::KIND_LOAD_FEAT: if (c < NFEAT) feat_mem[r*NFEAT+c] = v;
      lrgd_pkg::KIND_LOAD_TGT:  tgt_mem[r] = v;
      lrgd_pkg::KIND_SET_W:     if (c < NFEAT || c == lrgd_pkg::BIAS_IDX) wts[c] = v;
      lrgd_pkg::KIND_TRAIN: begin
        for (int e = 0; e < epoch_cnt; e++) one_epoch(n);
        for (int i = 0; i <= NFEAT; i++) begin
          res.idx  = (i < NFEAT) ? lrgd_pkg::IDX_W'(i) : lrgd_pkg::BIAS_IDX;
          res.wval = wts[res.idx];
          res.mse  = '0;
          res.last = (i == NFEAT);
          pending_q.push_back(res);
        end
      end
      lrgd_pkg::KIND_EVAL: begin
        refresh_errors(n);
        esum = 0;
        for (int i = 0; i < n; i++)
          esum += (longint'(err_mem[i]) * longint'(err_mem[i])) >> 16;
        esum = esum / longint'(n);
        if (esum > 64'hFFFF_FFFF_FFFF) esum = 64'hFFFF_FFFF_FFFF;
        res.idx  = '0;
        res.wval = '0;
        res.mse  = esum[lrgd_pkg::MSE_W-1:0];
        res.last = 1'b1;
        pending_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function void check_result(lr_result_t got);
    lr_result_t exp_r;
    if (pending_q.size() == 0) begin
      $error("unexpected result: index %0d value %h", got.idx, got.wval);
      fail_cnt++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (got.idx !== exp_r.idx) begin
      $error("weight_index: expected %0d, actual %0d", exp_r.idx, got.idx);
      fail_cnt++;
    end
    if (got.wval !== exp_r.wval) begin
      $error("weight_value: expected %h, actual %h", exp_r.wval, got.wval);
      fail_cnt++;
    end
    if (got.mse !== exp_r.mse) begin
      $error("mean_sq_error: expected %h, actual %h", exp_r.mse, got.mse);
      fail_cnt++;
    end
    if (got.last !== exp_r.last) begin
      $error("last: expected %b, actual %b", exp_r.last, got.last);
      fail_cnt++;
    end
  endfunction
endclass

module linear_regression_gd_trainer_tb;
  localparam int QUIET_LIMIT = 50_000;     // watchdog limit, above the longest silent train here
  localparam int LOAD_SETTLE = 8;          // cycles after loads before a config write
  localparam int DRAIN_TAIL  = 40;
  localparam int DEF_ROWS    = 3;          // rows loaded up front; row count stays within
  localparam int PHASES      = 3;
  localparam int PHASE_ITEMS = 20;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;  // kinds 5..7 are ignored
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam logic [lrgd_pkg::CFGI_W-1:0] CFG_SPARE = 2'd3;  // unused register index

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] kind = '0;
  logic [9:0] row = '0;
  logic [lrgd_pkg::IDX_W-1:0] column = '0;
  logic signed [lrgd_pkg::DATA_W-1:0] value = '0;
  logic cfg_we = 1'b0;
  logic [lrgd_pkg::CFGI_W-1:0] cfg_index = '0;
  logic [lrgd_pkg::CFG_W-1:0] cfg_data = '0;
  logic strobe;
  logic [lrgd_pkg::IDX_W-1:0] weight_index;
  logic signed [lrgd_pkg::DATA_W-1:0] weight_value;
  logic [lrgd_pkg::MSE_W-1:0] mean_sq_error;
  logic last;

  lr_scoreboard model = new();
  int burst_left = 0;
  int quiet_cycles = 0;

  linear_regression_gd_trainer dut (
    .clk, .rst, .start, .busy, .kind, .row, .column, .value,
    .cfg_we, .cfg_index, .cfg_data,
    .strobe, .weight_index, .weight_value, .mean_sq_error, .last
  );

  always #5 clk = ~clk;

  // results cannot be held off: every strobe is a transfer
  always @(posedge clk) begin
    if (!rst && strobe)
      model.check_result('{weight_index, weight_value, mean_sq_error, last});
  end

  // watchdog on cycles with no transfer on the command or result channel
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("linear_regression_gd_trainer verification failed");
      $finish;
    end
  end

  // one command transfer; start stays high inside a burst
  task automatic send_cmd(logic [2:0] k, logic [9:0] r, logic [5:0] c, int v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = int'($urandom_range(1, 12));
    end
    start  <= 1'b1;
    kind   <= k;
    row    <= r;
    column <= c;
    value  <= v;
    do @(posedge clk); while (busy);
    model.note_command(k, r, c, v);
    burst_left--;
  endtask

  // config only while idle: drain results, let loads settle, then write
  task automatic write_cfg(logic [lrgd_pkg::CFGI_W-1:0] idx, logic [lrgd_pkg::CFG_W-1:0] data);
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (model.pending_q.size() != 0) @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    model.set_cfg(idx, data);
  endtask

  function automatic int small_val();
    return int'($urandom_range(0, 262143)) - 131072;  // about +/-2.0
  endfunction

  function automatic int any_val();
    return ($urandom_range(0, 1) == 0) ? small_val() : int'($urandom());
  endfunction

  task automatic random_item();
    int pick;
    pick = int'($urandom_range(0, 99));
    if (pick < 33)
      send_cmd(lrgd_pkg::KIND_LOAD_FEAT, 10'($urandom_range(0, 1023)),
               6'($urandom_range(0, 31)), any_val());
    else if (pick < 48)
      send_cmd(lrgd_pkg::KIND_LOAD_TGT, ($urandom_range(0, 1) == 0) ?
               10'($urandom_range(0, DEF_ROWS - 1)) : 10'($urandom_range(0, 1023)),
               6'($urandom_range(0, 63)), any_val());
    else if (pick < 63)
      send_cmd(lrgd_pkg::KIND_SET_W, 10'($urandom_range(0, 1023)),
               ($urandom_range(0, 4) == 0) ? lrgd_pkg::BIAS_IDX : 6'($urandom_range(0, 31)),
               ($urandom_range(0, 5) == 0) ? int'($urandom()) : small_val() >>> 4);
    else if (pick < 75)
      send_cmd(lrgd_pkg::KIND_TRAIN, 10'($urandom_range(0, 1023)),
               6'($urandom_range(0, 63)), int'($urandom()));
    else if (pick < 88)
      send_cmd(lrgd_pkg::KIND_EVAL, 10'($urandom_range(0, 1023)),
               6'($urandom_range(0, 63)), int'($urandom()));
    else if (pick < 94)
      send_cmd(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), 10'($urandom_range(0, 1023)),
               6'($urandom_range(0, 63)), int'($urandom()));
    else if (pick < 97)  // feature column out of range: ignored
      send_cmd(lrgd_pkg::KIND_LOAD_FEAT, 10'($urandom_range(0, 1023)),
               6'($urandom_range(32, 63)), int'($urandom()));
    else                 // weight column neither feature nor bias: ignored
      send_cmd(lrgd_pkg::KIND_SET_W, 10'($urandom_range(0, 1023)),
               6'($urandom_range(33, 63)), int'($urandom()));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // define every row the row count can reach so no read hits an unwritten entry
    for (int r = 0; r < DEF_ROWS; r++) begin
      for (int c = 0; c < 32; c++)
        send_cmd(lrgd_pkg::KIND_LOAD_FEAT, 10'(r), 6'(c), small_val());
      send_cmd(lrgd_pkg::KIND_LOAD_TGT, 10'(r), 6'($urandom_range(0, 63)), small_val());
    end

    // directed: defaults, saturating values, ignored items
    send_cmd(lrgd_pkg::KIND_EVAL, 10'd0, 6'd0, 0);
    send_cmd(lrgd_pkg::KIND_TRAIN, 10'd0, 6'd0, 0);
    send_cmd(lrgd_pkg::KIND_SET_W, 10'd0, 6'd0, 32'h7FFFFFFF);
    send_cmd(lrgd_pkg::KIND_SET_W, 10'd0, lrgd_pkg::BIAS_IDX, 32'h80000000);
    send_cmd(lrgd_pkg::KIND_SET_W, 10'd0, 6'd33, 32'h12345678);
    send_cmd(lrgd_pkg::KIND_SET_W, 10'd0, 6'd63, 32'hFFFFFFFF);
    send_cmd(lrgd_pkg::KIND_LOAD_FEAT, 10'd0, 6'd0, 32'h7FFFFFFF);
    send_cmd(lrgd_pkg::KIND_LOAD_FEAT, 10'd1023, 6'd40, 32'h80000000);
    send_cmd(lrgd_pkg::KIND_LOAD_TGT, 10'd1023, 6'd0, 32'h80000000);
    send_cmd(lrgd_pkg::KIND_LOAD_TGT, 10'd0, 6'd0, 32'h80000000);
    send_cmd(lrgd_pkg::KIND_EVAL, 10'd0, 6'd0, 0);
    send_cmd(lrgd_pkg::KIND_TRAIN, 10'd0, 6'd0, 0);
    for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
      send_cmd(3'(k), 10'h3FF, 6'h3F, -1);
    // zero epochs: weights come back unchanged
    write_cfg(lrgd_pkg::CFG_EPOCH_COUNT, 16'd0);
    send_cmd(lrgd_pkg::KIND_TRAIN, 10'd0, 6'd0, 0);
    write_cfg(lrgd_pkg::CFG_LEARN_RATE, 16'd0);
    write_cfg(lrgd_pkg::CFG_EPOCH_COUNT, 16'd2);
    send_cmd(lrgd_pkg::KIND_SET_W, 10'd0, 6'd0, small_val());
    send_cmd(lrgd_pkg::KIND_SET_W, 10'd0, lrgd_pkg::BIAS_IDX, small_val());
    send_cmd(lrgd_pkg::KIND_TRAIN, 10'd0, 6'd0, 0);
    write_cfg(lrgd_pkg::CFG_LEARN_RATE, 16'hFFFF);
    write_cfg(lrgd_pkg::CFG_ROW_COUNT, 16'(DEF_ROWS));
    send_cmd(lrgd_pkg::KIND_TRAIN, 10'd0, 6'd0, 0);
    // row count 0 acts as one row
    write_cfg(lrgd_pkg::CFG_ROW_COUNT, 16'd0);
    send_cmd(lrgd_pkg::KIND_EVAL, 10'd0, 6'd0, 0);
    write_cfg(CFG_SPARE, 16'hA5A5);  // unused index, ignored
    write_cfg(lrgd_pkg::CFG_EPOCH_COUNT, 16'd1);
    write_cfg(lrgd_pkg::CFG_ROW_COUNT, 16'(DEF_ROWS));
    write_cfg(lrgd_pkg::CFG_LEARN_RATE, 16'd655);
    send_cmd(lrgd_pkg::KIND_TRAIN, 10'd0, 6'd0, 0);

    // random phases, each under its own small setting
    for (int ph = 0; ph < PHASES; ph++) begin
      write_cfg(lrgd_pkg::CFG_ROW_COUNT, 16'($urandom_range(1, DEF_ROWS)));
      write_cfg(lrgd_pkg::CFG_EPOCH_COUNT, 16'($urandom_range(0, 2)));
      case ($urandom_range(0, 3))
        0: write_cfg(lrgd_pkg::CFG_LEARN_RATE, 16'd0);
        1: write_cfg(lrgd_pkg::CFG_LEARN_RATE, 16'hFFFF);
        default: write_cfg(lrgd_pkg::CFG_LEARN_RATE, 16'($urandom_range(1, 65534)));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
    end

    start <= 1'b0;
    @(posedge clk);
    while (model.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (model.fail_cnt == 0 && model.pending_q.size() == 0)
      $display("linear_regression_gd_trainer verification clean");
    else
      $display("linear_regression_gd_trainer verification failed");
    $finish;
  end
endmodule
